### design/bct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and command codes for the binding cache table.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // request fields held for the whole scan
  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] coa_hi;
    logic [63:0] coa_lo;
    logic [15:0] lifetime;
    logic [15:0] seq_num;
    logic        home_reg;
  } req_t;

  // partial search result handed from cell to cell
  typedef struct packed {
    logic        hit;
    logic        free_seen;
    logic        coa_match;
    logic [63:0] coa_hi;
    logic [63:0] coa_lo;
    logic [15:0] lifetime;
    logic [15:0] seq_num;
    logic        home_reg;
  } carry_t;

  // update broadcast to all cells at the end of a scan
  typedef struct packed {
    logic wr;
    logic clr;
    logic sel_hit;
  } commit_t;

endpackage

### design/bct_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_ifs
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface bct_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] home_address_hi;
  logic [63:0] home_address_lo;
  logic [63:0] care_of_address_hi;
  logic [63:0] care_of_address_lo;
  logic [15:0] lifetime_in;
  logic [15:0] sequence_in;
  logic        home_reg_in;

  modport source (
    output valid, command, home_address_hi, home_address_lo,
           care_of_address_hi, care_of_address_lo, lifetime_in, sequence_in,
           home_reg_in,
    input  ready
  );
  modport sink (
    input  valid, command, home_address_hi, home_address_lo,
           care_of_address_hi, care_of_address_lo, lifetime_in, sequence_in,
           home_reg_in,
    output ready
  );
endinterface

interface bct_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        coa_matches;
  logic [63:0] stored_coa_hi;
  logic [63:0] stored_coa_lo;
  logic [15:0] stored_lifetime;
  logic [15:0] stored_sequence;
  logic        stored_home_reg;
  logic        table_full;

  modport source (
    output valid, found, coa_matches, stored_coa_hi, stored_coa_lo,
           stored_lifetime, stored_sequence, stored_home_reg, table_full,
    input  ready
  );
  modport sink (
    input  valid, found, coa_matches, stored_coa_hi, stored_coa_lo,
           stored_lifetime, stored_sequence, stored_home_reg, table_full,
    output ready
  );
endinterface

### design/bct_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bct_cell
// One table slot: compares its entry when the scan token arrives, merges its
// result into the carry from the previous cell and passes it on.
// ----------------------------------------------------------------------------
module bct_cell (
  input  logic             clk,
  input  logic             rst,
  input  bct_pkg::req_t    req,
  input  logic             tok_prev,
  input  bct_pkg::carry_t  carry_prev,
  input  bct_pkg::commit_t commit,
  output logic             tok,
  output bct_pkg::carry_t  carry
);

  logic            valid;
  logic            hit_mark;
  logic            free_mark;
  logic [63:0]     key_hi;
  logic [63:0]     key_lo;
  logic [63:0]     coa_hi;
  logic [63:0]     coa_lo;
  logic [15:0]     lifetime;
  logic [15:0]     seq_num;
  logic            home_reg;
  logic            hit;
  logic            wr_sel;
  bct_pkg::carry_t carry_next;

  assign hit    = valid && (key_hi == req.key_hi) && (key_lo == req.key_lo);
  assign wr_sel = commit.wr && (commit.sel_hit ? hit_mark : free_mark);

  always_comb begin
    carry_next           = carry_prev;
    carry_next.free_seen = carry_prev.free_seen || !valid;
    if (hit) begin
      carry_next.hit       = 1'b1;
      carry_next.coa_match = (coa_hi == req.coa_hi) && (coa_lo == req.coa_lo);
      carry_next.coa_hi    = coa_hi;
      carry_next.coa_lo    = coa_lo;
      carry_next.lifetime  = lifetime;
      carry_next.seq_num   = seq_num;
      carry_next.home_reg  = home_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      tok       <= 1'b0;
      hit_mark  <= 1'b0;
      free_mark <= 1'b0;
    end else begin
      tok <= tok_prev;
      if (tok_prev) begin
        hit_mark  <= hit;
        free_mark <= !valid && !carry_prev.free_seen;
      end
      if (wr_sel) begin
        valid <= 1'b1;
      end else if (commit.clr && hit_mark) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_prev) begin
      carry <= carry_next;
    end
    if (wr_sel) begin
      key_hi   <= req.key_hi;
      key_lo   <= req.key_lo;
      coa_hi   <= req.coa_hi;
      coa_lo   <= req.coa_lo;
      lifetime <= req.lifetime;
      seq_num  <= req.seq_num;
      home_reg <= req.home_reg;
    end
  end

endmodule

### design/binding_cache_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binding_cache_table
// Associative table of mobility bindings keyed by a 128-bit home address.
// ----------------------------------------------------------------------------
// One word is processed at a time. After a request word is accepted, a scan
// token steps through a row of CAPACITY cells, one cell per cycle, each cell
// comparing its entry and handing the merged result to the next. Once the
// token has left the last cell, the table is updated and the response loaded
// in the DONE state, which waits until any earlier response has been taken;
// only then does the block return to IDLE and take a new request. A new key
// goes into the lowest free slot; valid marks clear at reset with no further
// initialization.
module binding_cache_table #(
  parameter int CAPACITY = 16
) (
  input  logic     clk,
  input  logic     rst,
  bct_req_if.sink  request,
  bct_rsp_if.source response
);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;

  state_t            state;
  logic              start;
  logic [1:0]        cmd;
  bct_pkg::req_t     req;
  bct_pkg::commit_t  commit;
  bct_pkg::carry_t   last;
  logic              finish;
  logic              full;

  logic              tok   [CAPACITY];
  bct_pkg::carry_t   carry [CAPACITY];

  logic              rsp_valid;
  logic              rsp_found;
  logic              rsp_coa_matches;
  logic [63:0]       rsp_coa_hi;
  logic [63:0]       rsp_coa_lo;
  logic [15:0]       rsp_lifetime;
  logic [15:0]       rsp_sequence;
  logic              rsp_home_reg;
  logic              rsp_full;

  assign request.ready = (state == IDLE);
  assign last          = carry[CAPACITY-1];
  assign finish        = (state == DONE) && (!rsp_valid || response.ready);
  assign full          = !last.hit && !last.free_seen;

  always_comb begin
    commit         = '0;
    commit.sel_hit = last.hit;
    if (finish) begin
      case (cmd)
        bct_pkg::CMD_ADD: begin
          commit.wr = !full;
        end
        bct_pkg::CMD_DELETE: begin
          commit.clr = last.hit;
        end
        bct_pkg::CMD_LOOKUP: begin
        end
        default: begin
        end
      endcase
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
        bct_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .req        (req),
          .tok_prev   (start),
          .carry_prev (bct_pkg::carry_t'('0)),
          .commit     (commit),
          .tok        (tok[i]),
          .carry      (carry[i])
        );
      end else begin : g_body
        bct_cell u_cell (
          .clk        (clk),
          .rst        (rst),
          .req        (req),
          .tok_prev   (tok[i-1]),
          .carry_prev (carry[i-1]),
          .commit     (commit),
          .tok        (tok[i]),
          .carry      (carry[i])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      start     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      start <= 1'b0;
      if (rsp_valid && response.ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (request.valid) begin
            start <= 1'b1;
            state <= SCAN;
          end
        end
        SCAN: begin
          if (tok[CAPACITY-1]) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (finish) begin
            rsp_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      cmd          <= request.command;
      req.key_hi   <= request.home_address_hi;
      req.key_lo   <= request.home_address_lo;
      req.coa_hi   <= request.care_of_address_hi;
      req.coa_lo   <= request.care_of_address_lo;
      req.lifetime <= request.lifetime_in;
      req.seq_num  <= request.sequence_in;
      req.home_reg <= request.home_reg_in;
    end
    if (finish) begin
      rsp_found       <= last.hit;
      rsp_coa_matches <= last.hit && last.coa_match;
      rsp_coa_hi      <= last.coa_hi;
      rsp_coa_lo      <= last.coa_lo;
      rsp_lifetime    <= last.lifetime;
      rsp_sequence    <= last.seq_num;
      rsp_home_reg    <= last.home_reg;
      rsp_full        <= (cmd == bct_pkg::CMD_ADD) && full;
    end
  end

  assign response.valid           = rsp_valid;
  assign response.found           = rsp_found;
  assign response.coa_matches     = rsp_coa_matches;
  assign response.stored_coa_hi   = rsp_coa_hi;
  assign response.stored_coa_lo   = rsp_coa_lo;
  assign response.stored_lifetime = rsp_lifetime;
  assign response.stored_sequence = rsp_sequence;
  assign response.stored_home_reg = rsp_home_reg;
  assign response.table_full      = rsp_full;

endmodule

### dv/binding_cache_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binding_cache_table_test
// Self-checking bench for the binding cache table.
// ----------------------------------------------------------------------------
// A scoreboard object keeps a shadow copy of the binding slots. It predicts
// the response word for every accepted request word and compares each
// accepted response word, field by field, against the oldest prediction.
// A directed run covers empty, full and near-miss cases, and it is followed
// by random phases that are biased toward adds, deletes or lookups over a
// small pool of keys. Both channels idle at random, except in one quiet phase.
// ----------------------------------------------------------------------------
module binding_cache_table_test;

  localparam int         CAPACITY   = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]    command;
    bct_pkg::req_t body;
  } bind_req_t;

  typedef struct packed {
    logic        found;
    logic        coa_matches;
    logic [63:0] stored_coa_hi;
    logic [63:0] stored_coa_lo;
    logic [15:0] stored_lifetime;
    logic [15:0] stored_sequence;
    logic        stored_home_reg;
    logic        table_full;
  } bind_rsp_t;

  class binding_scoreboard;
    logic          slot_used [CAPACITY];
    bct_pkg::req_t slot_data [CAPACITY];
    bind_rsp_t     pending [$];
    int            errors;
    int            checked;

    function new();
      int i;
      for (i = 0; i < CAPACITY; i++) begin
        slot_used[i] = 1'b0;
        slot_data[i] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void note_request(bind_req_t w);
      bind_rsp_t r;
      int        hit;
      int        slot;
      int        i;
      r    = '0;
      hit  = -1;
      slot = -1;
      for (i = 0; i < CAPACITY; i++) begin
        if (hit < 0 && slot_used[i] && slot_data[i].key_hi == w.body.key_hi &&
            slot_data[i].key_lo == w.body.key_lo) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        r.found           = 1'b1;
        r.coa_matches     = (slot_data[hit].coa_hi == w.body.coa_hi) &&
                            (slot_data[hit].coa_lo == w.body.coa_lo);
        r.stored_coa_hi   = slot_data[hit].coa_hi;
        r.stored_coa_lo   = slot_data[hit].coa_lo;
        r.stored_lifetime = slot_data[hit].lifetime;
        r.stored_sequence = slot_data[hit].seq_num;
        r.stored_home_reg = slot_data[hit].home_reg;
      end
      if (w.command == bct_pkg::CMD_ADD) begin
        slot = hit;
        for (i = 0; i < CAPACITY; i++) begin
          if (slot < 0 && !slot_used[i]) slot = i;
        end
        if (slot < 0) begin
          r.table_full = 1'b1;
        end else begin
          slot_used[slot] = 1'b1;
          slot_data[slot] = w.body;
        end
      end else if (w.command == bct_pkg::CMD_DELETE && hit >= 0) begin
        slot_used[hit] = 1'b0;
      end
      pending.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at response word %0d: %s", checked, msg);
      errors++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
        report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
    endtask

    task check_response(bind_rsp_t got);
      bind_rsp_t want;
      if (pending.size() == 0) begin
        report_mismatch("response word with none expected");
      end else begin
        want = pending.pop_front();
        compare_field("found", 64'(got.found), 64'(want.found));
        compare_field("coa_matches", 64'(got.coa_matches), 64'(want.coa_matches));
        compare_field("stored_coa_hi", got.stored_coa_hi, want.stored_coa_hi);
        compare_field("stored_coa_lo", got.stored_coa_lo, want.stored_coa_lo);
        compare_field("stored_lifetime", 64'(got.stored_lifetime),
                      64'(want.stored_lifetime));
        compare_field("stored_sequence", 64'(got.stored_sequence),
                      64'(want.stored_sequence));
        compare_field("stored_home_reg", 64'(got.stored_home_reg),
                      64'(want.stored_home_reg));
        compare_field("table_full", 64'(got.table_full), 64'(want.table_full));
      end
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic quiet = 1'b0;

  logic [63:0] key_hi_pool [6];
  logic [63:0] key_lo_pool [4];
  logic [63:0] coa_hi_pool [4];
  logic [63:0] coa_lo_pool [4];

  binding_scoreboard sb;

  bct_req_if req_ch ();
  bct_rsp_if rsp_ch ();

  binding_cache_table #(
    .CAPACITY (CAPACITY)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .request  (req_ch),
    .response (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= 22);
    end
  end

  // new request is noted before the response check; queue order keeps them apart
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request({req_ch.command, req_ch.home_address_hi, req_ch.home_address_lo,
                         req_ch.care_of_address_hi, req_ch.care_of_address_lo,
                         req_ch.lifetime_in, req_ch.sequence_in, req_ch.home_reg_in});
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_response({rsp_ch.found, rsp_ch.coa_matches, rsp_ch.stored_coa_hi,
                           rsp_ch.stored_coa_lo, rsp_ch.stored_lifetime,
                           rsp_ch.stored_sequence, rsp_ch.stored_home_reg,
                           rsp_ch.table_full});
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bind_req_t binding_word(logic [1:0] cmd, logic [63:0] khi,
                                             logic [63:0] klo, logic [63:0] chi,
                                             logic [63:0] clo, logic [15:0] life,
                                             logic [15:0] seq, logic hreg);
    bind_req_t w;
    w.command       = cmd;
    w.body.key_hi   = khi;
    w.body.key_lo   = klo;
    w.body.coa_hi   = chi;
    w.body.coa_lo   = clo;
    w.body.lifetime = life;
    w.body.seq_num  = seq;
    w.body.home_reg = hreg;
    return w;
  endfunction

  function automatic bind_req_t random_word(int add_pct, int del_pct);
    bind_req_t w;
    int        pick;
    int        ci;
    pick = $urandom_range(99);
    if (pick < add_pct) w.command = bct_pkg::CMD_ADD;
    else if (pick < add_pct + del_pct) w.command = bct_pkg::CMD_DELETE;
    else if (pick < 97) w.command = bct_pkg::CMD_LOOKUP;
    else w.command = CMD_UNUSED;
    if ($urandom_range(99) < 6) begin
      w.body.key_hi = rand64();
      w.body.key_lo = rand64();
    end else begin
      w.body.key_hi = key_hi_pool[$urandom_range(5)];
      w.body.key_lo = key_lo_pool[$urandom_range(3)];
    end
    ci = $urandom_range(3);
    w.body.coa_hi = coa_hi_pool[ci];
    w.body.coa_lo = coa_lo_pool[ci];
    case ($urandom_range(9))
      0: w.body.coa_hi = rand64();
      1: w.body.coa_lo = rand64();
      2: w.body.coa_lo = coa_lo_pool[(ci + 1) % 4];
      default: ;
    endcase
    w.body.lifetime = 16'($urandom);
    w.body.seq_num  = 16'($urandom);
    w.body.home_reg = 1'($urandom);
    return w;
  endfunction

  task automatic send_word(input bind_req_t w);
    req_ch.valid              <= 1'b1;
    req_ch.command            <= w.command;
    req_ch.home_address_hi    <= w.body.key_hi;
    req_ch.home_address_lo    <= w.body.key_lo;
    req_ch.care_of_address_hi <= w.body.coa_hi;
    req_ch.care_of_address_lo <= w.body.coa_lo;
    req_ch.lifetime_in        <= w.body.lifetime;
    req_ch.sequence_in        <= w.body.seq_num;
    req_ch.home_reg_in        <= w.body.home_reg;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (!quiet && $urandom_range(99) < 22) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  initial begin
    int          idx;
    int          n;
    int          phase;
    int          add_pct [6];
    int          del_pct [6];
    logic [63:0] ones;

    sb = new();
    ones = '1;
    add_pct = '{60, 15, 35, 45, 10, 30};
    del_pct = '{10, 60, 30, 20, 20, 35};

    req_ch.valid              <= 1'b0;
    req_ch.command            <= bct_pkg::CMD_LOOKUP;
    req_ch.home_address_hi    <= '0;
    req_ch.home_address_lo    <= '0;
    req_ch.care_of_address_hi <= '0;
    req_ch.care_of_address_lo <= '0;
    req_ch.lifetime_in        <= '0;
    req_ch.sequence_in        <= '0;
    req_ch.home_reg_in        <= 1'b0;

    key_hi_pool[0] = '0;
    key_hi_pool[1] = '1;
    for (idx = 2; idx < 6; idx++) key_hi_pool[idx] = rand64();
    key_lo_pool[0] = '0;
    key_lo_pool[1] = '1;
    coa_hi_pool[0] = '0;
    coa_hi_pool[1] = '1;
    coa_lo_pool[0] = '0;
    coa_lo_pool[1] = '1;
    for (idx = 2; idx < 4; idx++) begin
      key_lo_pool[idx] = rand64();
      coa_hi_pool[idx] = rand64();
      coa_lo_pool[idx] = rand64();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty table, then the extreme keys and data
    send_word(binding_word(bct_pkg::CMD_LOOKUP, ones, ones, ones, ones, '1, '1, 1'b1));
    send_word(binding_word(bct_pkg::CMD_DELETE, ones, ones, '0, '0, '0, '0, 1'b0));
    send_word(binding_word(bct_pkg::CMD_ADD, '0, '0, '0, '0, '0, '0, 1'b0));
    send_word(binding_word(bct_pkg::CMD_ADD, ones, ones, ones, ones, '1, '1, 1'b1));
    send_word(binding_word(bct_pkg::CMD_LOOKUP, ones, ones, ones, ones, '0, '0, 1'b0));
    send_word(binding_word(bct_pkg::CMD_LOOKUP, ones, ones, ones, '0, '0, '0, 1'b0));
    // near-miss key through the unused command code
    send_word(binding_word(CMD_UNUSED, ones, '0, ones, ones, '1, '1, 1'b1));
    send_word(binding_word(bct_pkg::CMD_ADD, '0, '0, rand64(), rand64(), 16'h5a5a,
                           16'ha5a5, 1'b1));
    send_word(binding_word(bct_pkg::CMD_DELETE, ones, ones, ones, ones, '0, '0, 1'b0));

    // fill every slot from the key pool, then overflow and update while full
    for (idx = 1; idx <= 16; idx++) begin
      if (idx != 5) begin
        send_word(binding_word(bct_pkg::CMD_ADD, key_hi_pool[idx / 4],
                               key_lo_pool[idx % 4],
                               coa_hi_pool[idx % 4], coa_lo_pool[idx % 4],
                               16'($urandom), 16'($urandom), 1'($urandom)));
      end
    end
    send_word(binding_word(bct_pkg::CMD_ADD, rand64(), rand64(), ones, ones, '1, '1, 1'b1));
    send_word(binding_word(bct_pkg::CMD_ADD, '0, '0, ones, ones, '1, '1, 1'b0));

    for (phase = 0; phase < 6; phase++) begin
      quiet <= (phase == 2);
      for (n = 0; n < 171; n++) begin
        send_word(random_word(add_pct[phase], del_pct[phase]));
      end
    end
    req_ch.valid <= 1'b0;
    quiet        <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
